FILE: src/pps_pkg.sv
// shared types and constants for the preemptive priority scheduler
// no dependencies

package pps_pkg;

	localparam int MAX_TASKS = 16;
	localparam int SLOT_W    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int TIME_W    = 20;
	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	typedef struct packed {
		logic        action;
		logic [3:0]  slot;
		logic [15:0] arrival;
		logic [15:0] burst;
		logic [7:0]  prio;
	} pps_in_t;

	typedef struct packed {
		logic              ran_valid;
		logic [3:0]        ran_slot;
		logic              finished;
		logic [TIME_W-1:0] finish_time;
		logic              all_done;
	} pps_out_t;

	// one task table row as held in the memory
	typedef struct packed {
		logic [15:0] arrival;
		logic [7:0]  prio;
		logic [15:0] remaining;
	} pps_entry_t;

	// controls for the selection unit
	typedef struct packed {
		logic              clear;
		logic              cand_valid;
		logic [SLOT_W-1:0] cand_idx;
	} pps_pick_ctl_t;

	// running best candidate
	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] idx;
		logic [15:0]       arrival;
		logic [7:0]        prio;
		logic [15:0]       remaining;
	} pps_best_t;

endpackage

FILE: src/pps_pick.sv
// selection unit: compares one table row per cycle against the best so far
// depends on pps_pkg

module pps_pick import pps_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  pps_pick_ctl_t     ctl,
	input  pps_entry_t        cand,
	input  logic [TIME_W-1:0] now,
	output pps_best_t         best_nxt
);

	logic      found_q;
	pps_best_t best_q;
	logic      eligible;
	logic      better;

	// task must have arrived by now
	assign eligible = ctl.cand_valid && ({{(TIME_W-16){1'b0}}, cand.arrival} <= now);

	// lower priority number wins, then earlier arrival; later slots lose ties
	assign better = !found_q || (cand.prio < best_q.prio) ||
		((cand.prio == best_q.prio) && (cand.arrival < best_q.arrival));

	always_comb begin
		best_nxt       = best_q;
		best_nxt.found = found_q;
		if (eligible && better) begin
			best_nxt.found     = 1'b1;
			best_nxt.idx       = ctl.cand_idx;
			best_nxt.arrival   = cand.arrival;
			best_nxt.prio      = cand.prio;
			best_nxt.remaining = cand.remaining;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.clear) begin
			found_q <= 1'b0;
		end else begin
			found_q <= best_nxt.found;
		end
	end

	always_ff @(posedge clk) begin
		best_q <= best_nxt;
	end

endmodule

FILE: src/preemptive_priority_scheduler.sv
// a load gives its result in the cycle after the transfer, and busy stays low
// a tick steps through the scan and last states and commits in the last; busy stays high until the commit
// throughput: one load per cycle while idle, ticks one at a time: the single memory read port
//   visits one task slot per cycle, the last state commits, and idle takes the next transfer
// reset: active flags and time cleared at once, no clearing pass; results cannot be held off
// depends on pps_pkg and pps_pick

module preemptive_priority_scheduler import pps_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  pps_in_t  cmd,
	output logic     done,
	output pps_out_t result
);

	// sequencer codes
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_LAST = 2'd2;

	localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(MAX_TASKS - 1);

	logic [1:0]           state_q;
	logic [SLOT_W-1:0]    idx_q;
	logic                 vld_s1;
	logic [SLOT_W-1:0]    idx_s1;
	logic [MAX_TASKS-1:0] active_q;
	logic [MAX_TASKS-1:0] active_d;
	logic [TIME_W-1:0]    time_q;
	logic [TIME_W-1:0]    time_inc;

	// task table memory, one row per slot, registered read
	pps_entry_t mem_q [MAX_TASKS];
	pps_entry_t rd_q;
	logic              mem_we;
	logic [SLOT_W-1:0] mem_wa;
	pps_entry_t        mem_wd;

	logic          acc;
	logic          load_acc;
	logic          tick_acc;
	logic          load_ok;
	logic [SLOT_W-1:0] load_idx;
	pps_pick_ctl_t pick_ctl;
	pps_best_t     best;
	logic          commit;
	logic [15:0]   rem_dec;
	logic          fin;

	logic     done_q;
	pps_out_t result_q;

	assign busy     = (state_q != ST_IDLE);
	assign acc      = start && !busy;
	assign load_acc = acc && (cmd.action == ACT_LOAD);
	assign tick_acc = acc && (cmd.action == ACT_TICK);

	// loads past the table are dropped
	assign load_ok  = ({28'd0, cmd.slot} < 32'(MAX_TASKS));
	assign load_idx = SLOT_W'(cmd.slot);

	// saturating time step
	assign time_inc = (time_q == TIME_MAX) ? TIME_MAX : time_q + TIME_W'(1);

	// selection unit sees each row the cycle after its read
	always_comb begin
		pick_ctl.clear      = tick_acc;
		pick_ctl.cand_valid = vld_s1 && active_q[idx_s1];
		pick_ctl.cand_idx   = idx_s1;
	end

	pps_pick u_pick (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (pick_ctl),
		.cand     (rd_q),
		.now      (time_q),
		.best_nxt (best)
	);

	// final compare and write-back share the last cycle
	assign commit  = (state_q == ST_LAST);
	assign rem_dec = best.remaining - 16'd1;
	assign fin     = best.found && (rem_dec == 16'd0);

	// one write port: a load at its transfer, or the chosen row at commit;
	// busy keeps the two apart so no read overlaps a write
	always_comb begin
		mem_we = 1'b0;
		mem_wa = load_idx;
		mem_wd = '{arrival: cmd.arrival, prio: cmd.prio, remaining: cmd.burst};
		if (commit) begin
			mem_we = best.found;
			mem_wa = best.idx;
			mem_wd = '{arrival: best.arrival, prio: best.prio, remaining: rem_dec};
		end else if (load_acc) begin
			mem_we = load_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa] <= mem_wd;
		end
		if (state_q == ST_SCAN) begin
			rd_q <= mem_q[idx_q];
		end
	end

	// active flags after this cycle, for all_done
	always_comb begin
		active_d = active_q;
		if (load_acc && load_ok) begin
			active_d[load_idx] = (cmd.burst != 16'd0);
		end else if (commit && fin) begin
			active_d[best.idx] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			idx_q    <= '0;
			vld_s1   <= 1'b0;
			idx_s1   <= '0;
			active_q <= '0;
			time_q   <= '0;
			done_q   <= 1'b0;
		end else begin
			active_q <= active_d;
			vld_s1   <= (state_q == ST_SCAN);
			idx_s1   <= idx_q;
			done_q   <= load_acc || commit;
			unique case (state_q)
				ST_IDLE: begin
					if (tick_acc) begin
						state_q <= ST_SCAN;
						idx_q   <= '0;
					end
				end
				ST_SCAN: begin
					if (idx_q == LAST_IDX) begin
						state_q <= ST_LAST;
					end else begin
						idx_q <= idx_q + SLOT_W'(1);
					end
				end
				ST_LAST: begin
					state_q <= ST_IDLE;
					time_q  <= time_inc;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result register, payload only
	always_ff @(posedge clk) begin
		result_q.ran_valid   <= commit && best.found;
		result_q.ran_slot    <= (commit && best.found) ? 4'(best.idx) : 4'd0;
		result_q.finished    <= commit && fin;
		result_q.finish_time <= (commit && fin) ? time_inc : '0;
		result_q.all_done    <= (active_d == '0);
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

FILE: src/pps_checker.sv
// port-level checks for the preemptive priority scheduler, bound to the top level
// depends on pps_pkg

module pps_checker import pps_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input pps_in_t  cmd,
	input logic     done,
	input pps_out_t result
);

	// an idle tick or a load reports no slot and no completion
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.ran_valid |-> result.ran_slot == 4'd0 && !result.finished
			&& result.finish_time == '0)
		else $error("result without a run carries slot or finish data");

	// a completion belongs to a run and finishes no earlier than time one
	a_fin_ran: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.finished |-> result.ran_valid && result.finish_time != '0)
		else $error("completion without a run");

	// a load with work leaves at least one task active
	a_load_active: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd.action == ACT_LOAD && cmd.burst != 16'd0
			|=> done && !busy && !result.all_done)
		else $error("load with work reported all done");

	// a tick holds the block busy and gives no result at once
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd.action == ACT_TICK |=> busy && !done)
		else $error("tick did not occupy the block");

	// the end of a tick always delivers its result
	a_tick_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("tick ended without a result");

endmodule

bind preemptive_priority_scheduler pps_checker u_pps_checker (.*);
